/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the CAN frame slot assigner.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Condition must never be true outside reset.
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_NEVER(label, cond, msg)
`endif
`endif

/* rtl/cfsa_pkg.sv */
// Package for the CAN frame slot assigner: constants, status codes and types.
// No dependencies; used by cfsa_slot_table and can_frame_slot_assigner.
package cfsa_pkg;

	localparam int NUM_SLOTS_DEF    = 16;
	localparam int NUM_OUTPUTS_DEF  = 32;
	localparam int DEFAULT_INTERVAL = 100;
	localparam int MAX_BITS         = 64;
	localparam int BITS_PER_BYTE    = 8;

	localparam logic CMD_CLEAR  = 1'b0;
	localparam logic CMD_ASSIGN = 1'b1;

	localparam logic [2:0] ST_MERGED  = 3'd0;
	localparam logic [2:0] ST_NEW     = 3'd1;
	localparam logic [2:0] ST_SKIPPED = 3'd2;
	localparam logic [2:0] ST_FULL    = 3'd3;
	localparam logic [2:0] ST_CLEARED = 3'd4;

	typedef struct packed {
		logic        ext;
		logic [15:0] ident;
		logic [4:0]  len_code;
		logic [15:0] period;
	} cfsa_slot_t;

	typedef struct packed {
		logic write;
		logic clear;
	} cfsa_tbl_ctl_t;

endpackage

/* rtl/can_frame_slot_assigner.sv */
// CAN frame slot assigner: an assign transaction scans the slot table one entry per cycle,
// merging into the first matching slot or taking the first free one. Depends on cfsa_pkg.
// Clear and skipped items go straight to the finish state; assign items scan until a match or
// the last slot, walking the single table read port one slot a cycle. A new item is accepted
// only once the last one has left the finish state, and output stalls hold it there.
// Reset empties the table and the output map at once through per-entry used bits.
`include "assert_macros.svh"
module can_frame_slot_assigner import cfsa_pkg::*; #(
	parameter int NUM_SLOTS   = NUM_SLOTS_DEF,
	parameter int NUM_OUTPUTS = NUM_OUTPUTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        cmd,
	input  logic [4:0]  output_index,
	input  logic        enabled,
	input  logic        extended,
	input  logic [15:0] frame_id,
	input  logic [5:0]  start_bit,
	input  logic [7:0]  bit_length,
	input  logic [15:0] interval,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [3:0]  slot,
	output logic [4:0]  slot_dlc,
	output logic [15:0] slot_interval
);

	localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CW = $clog2(NUM_SLOTS + 1);
	localparam int OW = (NUM_OUTPUTS > 1) ? $clog2(NUM_OUTPUTS) : 1;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SCAN   = 2'd1;
	localparam logic [1:0] S_FINISH = 2'd2;

	logic [1:0]        state_q;
	logic [CW-1:0]     cnt_q;
	logic              cmp_vld_s1;
	logic [SW-1:0]     cmp_idx_s1;
	logic              free_found_q;
	logic [SW-1:0]     free_idx_q;

	// item registers
	logic              ext_q;
	logic [15:0]       id_q;
	logic [4:0]        dlc_q;
	logic [15:0]       iv_q;
	logic [4:0]        oidx_q;

	// pending result
	logic [2:0]        res_status_q;
	logic [SW-1:0]     res_idx_q;
	logic [4:0]        res_lc_q;
	logic [15:0]       res_iv_q;

	logic              out_valid_q;
	logic [2:0]        status_q;
	logic [3:0]        slot_q;
	logic [4:0]        slot_dlc_q;
	logic [15:0]       slot_interval_q;

	logic [SW-1:0]     map_mem [NUM_OUTPUTS];
	logic [NUM_OUTPUTS-1:0] map_vld_q;

	logic              accept;
	logic              skip;
	logic [6:0]        end_bit;
	logic [4:0]        dlc_new;
	logic              rd_en;
	cfsa_slot_t        rd_entry;
	logic              rd_used;
	logic              hit;
	logic              scan_last;
	logic              finish_go;
	logic              slot_write;
	cfsa_tbl_ctl_t     tbl_ctl;
	cfsa_slot_t        wr_entry;
	logic              map_in_range;
	logic [OW-1:0]     map_idx;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);

	assign skip    = !enabled || (bit_length == 8'd0) || (bit_length > 8'(MAX_BITS));
	assign end_bit = 7'(start_bit) + 7'(bit_length) - 7'd1;
	assign dlc_new = 5'(end_bit / 7'(BITS_PER_BYTE)) + 5'd1;

	assign rd_en     = (state_q == S_SCAN) && (cnt_q < CW'(NUM_SLOTS));
	assign hit       = cmp_vld_s1 && rd_used && (rd_entry.ext == ext_q)
		&& (rd_entry.ident == id_q);
	assign scan_last = cmp_vld_s1 && (cmp_idx_s1 == SW'(NUM_SLOTS - 1));

	assign finish_go  = (state_q == S_FINISH) && (!out_valid_q || !out_stall);
	assign slot_write = finish_go && ((res_status_q == ST_MERGED) || (res_status_q == ST_NEW));

	assign tbl_ctl.write = slot_write;
	assign tbl_ctl.clear = finish_go && (res_status_q == ST_CLEARED);
	assign wr_entry.ext      = ext_q;
	assign wr_entry.ident    = id_q;
	assign wr_entry.len_code = res_lc_q;
	assign wr_entry.period   = res_iv_q;

	assign map_in_range = (32'(oidx_q) < 32'(NUM_OUTPUTS));
	assign map_idx      = OW'(oidx_q);

	cfsa_slot_table #(
		.NUM_SLOTS(NUM_SLOTS)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (rd_en),
		.rd_addr  (cnt_q[SW-1:0]),
		.rd_entry (rd_entry),
		.rd_used  (rd_used),
		.ctl      (tbl_ctl),
		.wr_addr  (res_idx_q),
		.wr_entry (wr_entry)
	);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			cmp_vld_s1   <= 1'b0;
			free_found_q <= 1'b0;
			out_valid_q  <= 1'b0;
			map_vld_q    <= '0;
		end else begin
			if (finish_go) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cnt_q        <= '0;
						cmp_vld_s1   <= 1'b0;
						free_found_q <= 1'b0;
						if (cmd == CMD_CLEAR || skip) begin
							state_q <= S_FINISH;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					cmp_vld_s1 <= rd_en;
					if (rd_en) begin
						cnt_q <= cnt_q + CW'(1);
					end
					if (cmp_vld_s1 && !rd_used && !free_found_q) begin
						free_found_q <= 1'b1;
					end
					if (hit || scan_last) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (finish_go) begin
						state_q <= S_IDLE;
						if (res_status_q == ST_CLEARED) begin
							map_vld_q <= '0;
						end else if (map_in_range) begin
							map_vld_q[map_idx] <= slot_write;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		cmp_idx_s1 <= cnt_q[SW-1:0];
		if (accept) begin
			ext_q     <= extended;
			id_q      <= frame_id;
			dlc_q     <= dlc_new;
			iv_q      <= (interval == 16'd0) ? 16'(DEFAULT_INTERVAL) : interval;
			oidx_q    <= output_index;
			res_idx_q <= '0;
			res_lc_q  <= '0;
			res_iv_q  <= '0;
			if (cmd == CMD_CLEAR) begin
				res_status_q <= ST_CLEARED;
			end else if (skip) begin
				res_status_q <= ST_SKIPPED;
			end else begin
				res_status_q <= ST_FULL;
			end
		end
		if (state_q == S_SCAN) begin
			if (cmp_vld_s1 && !rd_used && !free_found_q) begin
				free_idx_q <= cmp_idx_s1;
			end
			if (hit) begin
				res_status_q <= ST_MERGED;
				res_idx_q    <= cmp_idx_s1;
				res_lc_q     <= (rd_entry.len_code < dlc_q) ? dlc_q : rd_entry.len_code;
				res_iv_q     <= (rd_entry.period > iv_q) ? iv_q : rd_entry.period;
			end else if (scan_last && (free_found_q || !rd_used)) begin
				res_status_q <= ST_NEW;
				res_idx_q    <= free_found_q ? free_idx_q : cmp_idx_s1;
				res_lc_q     <= dlc_q;
				res_iv_q     <= iv_q;
			end
		end
		if (finish_go) begin
			status_q        <= res_status_q;
			slot_q          <= 4'(res_idx_q);
			slot_dlc_q      <= res_lc_q;
			slot_interval_q <= res_iv_q;
			if (slot_write && map_in_range) begin
				map_mem[map_idx] <= res_idx_q;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign slot          = slot_q;
	assign slot_dlc      = slot_dlc_q;
	assign slot_interval = slot_interval_q;

	`ASSERT_CLK(a_accept_busy, accept |=> in_stall, "accepted transaction did not start work")
	`ASSERT_CLK(a_empty_result,
		out_valid && (status == ST_SKIPPED || status == ST_FULL || status == ST_CLEARED)
		|-> (slot == 4'd0 && slot_dlc == 5'd0 && slot_interval == 16'd0),
		"result without slot carries nonzero fields")
	`ASSERT_CLK(a_slot_result,
		out_valid && (status == ST_MERGED || status == ST_NEW)
		|-> (slot_dlc != 5'd0 && slot_dlc <= 5'd16 && slot_interval != 16'd0),
		"slot result has bad length code or interval")
	`ASSERT_NEVER(a_status_code, out_valid && status > ST_CLEARED, "undefined status code")

endmodule

/* rtl/cfsa_slot_table.sv */
// Slot table memory: one synchronous (registered) read port, one write port,
// and a used bit per slot that a clear empties at once. Depends on cfsa_pkg.
module cfsa_slot_table import cfsa_pkg::*; #(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF,
	localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic [SW-1:0] rd_addr,
	output cfsa_slot_t    rd_entry,
	output logic          rd_used,
	input  cfsa_tbl_ctl_t ctl,
	input  logic [SW-1:0] wr_addr,
	input  cfsa_slot_t    wr_entry
);

	cfsa_slot_t             mem [NUM_SLOTS];
	cfsa_slot_t             rd_entry_q;
	logic                   rd_used_q;
	logic [NUM_SLOTS-1:0]   used_q;

	always_ff @(posedge clk) begin
		if (ctl.write) begin
			mem[wr_addr] <= wr_entry;
		end
		if (rd_en) begin
			rd_entry_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q    <= '0;
			rd_used_q <= 1'b0;
		end else begin
			if (ctl.clear) begin
				used_q <= '0;
			end else if (ctl.write) begin
				used_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_used_q <= used_q[rd_addr];
			end
		end
	end

	assign rd_entry = rd_entry_q;
	assign rd_used  = rd_used_q;

endmodule

/* bench/tb_can_frame_slot_assigner.sv */
// Testbench for can_frame_slot_assigner: directed slot-table cases, then random clear/assign
// sequences under random idling on both channels, checked against a slot-table predictor.
// Depends on cfsa_pkg and the can_frame_slot_assigner RTL.
module tb_can_frame_slot_assigner import cfsa_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 700;
	localparam logic [4:0] MAP_NONE = 5'h1F;

	typedef struct {
		logic        cmd;
		logic [4:0]  out_idx;
		logic        enabled;
		logic        extended;
		logic [15:0] frame_id;
		logic [5:0]  start_bit;
		logic [7:0]  bit_length;
		logic [15:0] interval;
	} assign_req_t;

	typedef struct {
		logic [2:0]  status;
		logic [3:0]  slot;
		logic [4:0]  dlc;
		logic [15:0] period;
	} slot_reply_t;

	class frame_slot_tracker;
		bit [4:0]    len_code[NUM_SLOTS_DEF];
		bit          ext_flag[NUM_SLOTS_DEF];
		bit [15:0]   ident[NUM_SLOTS_DEF];
		bit [15:0]   period[NUM_SLOTS_DEF];
		bit [4:0]    out_map[NUM_OUTPUTS_DEF];
		slot_reply_t pending_replies[$];
		int          failures;

		function new();
			wipe_table();
			failures = 0;
		endfunction

		function void wipe_table();
			foreach (len_code[j]) begin
				len_code[j] = '0;
				ext_flag[j] = 1'b0;
				ident[j]    = '0;
				period[j]   = '0;
			end
			foreach (out_map[k])
				out_map[k] = MAP_NONE;
		endfunction

		function void record_output(logic [4:0] idx, bit [4:0] entry);
			if (idx < NUM_OUTPUTS_DEF)
				out_map[idx] = entry;
		endfunction

		function slot_reply_t predict_slot(assign_req_t r);
			slot_reply_t rep;
			logic [15:0] iv;
			int          dlc;
			int          hit;
			rep = '{default: '0};
			if (r.cmd == CMD_CLEAR) begin
				wipe_table();
				rep.status = ST_CLEARED;
				return rep;
			end
			if (!r.enabled || r.bit_length == 0 || r.bit_length > MAX_BITS) begin
				record_output(r.out_idx, MAP_NONE);
				rep.status = ST_SKIPPED;
				return rep;
			end
			iv  = (r.interval == 0) ? 16'(DEFAULT_INTERVAL) : r.interval;
			dlc = (int'(r.start_bit) + int'(r.bit_length) - 1) / BITS_PER_BYTE + 1;
			hit = -1;
			for (int j = 0; j < NUM_SLOTS_DEF && hit < 0; j++)
				if (len_code[j] != 0 && ext_flag[j] == r.extended && ident[j] == r.frame_id)
					hit = j;
			if (hit >= 0) begin
				// merge: keep the longer frame and the faster interval
				if (len_code[hit] < dlc)
					len_code[hit] = 5'(dlc);
				if (period[hit] > iv)
					period[hit] = iv;
				rep.status = ST_MERGED;
			end else begin
				for (int j = 0; j < NUM_SLOTS_DEF && hit < 0; j++)
					if (len_code[j] == 0)
						hit = j;
				if (hit < 0) begin
					record_output(r.out_idx, MAP_NONE);
					rep.status = ST_FULL;
					return rep;
				end
				ext_flag[hit] = r.extended;
				ident[hit]    = r.frame_id;
				len_code[hit] = 5'(dlc);
				period[hit]   = iv;
				rep.status    = ST_NEW;
			end
			record_output(r.out_idx, 5'(hit));
			rep.slot   = 4'(hit);
			rep.dlc    = len_code[hit];
			rep.period = period[hit];
			return rep;
		endfunction

		function void accept_request(assign_req_t r);
			pending_replies.push_back(predict_slot(r));
		endfunction

		function void compare_reply(slot_reply_t got);
			slot_reply_t want;
			if (pending_replies.size() == 0) begin
				$error("unexpected result: status %0d slot %0d slot_dlc %0d slot_interval %0d",
					got.status, got.slot, got.dlc, got.period);
				failures++;
				return;
			end
			want = pending_replies.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, got.status);
				failures++;
			end
			if (got.slot !== want.slot) begin
				$error("slot: expected %0d, actual %0d", want.slot, got.slot);
				failures++;
			end
			if (got.dlc !== want.dlc) begin
				$error("slot_dlc: expected %0d, actual %0d", want.dlc, got.dlc);
				failures++;
			end
			if (got.period !== want.period) begin
				$error("slot_interval: expected %0d, actual %0d", want.period, got.period);
				failures++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        cmd;
	logic [4:0]  output_index;
	logic        enabled;
	logic        extended;
	logic [15:0] frame_id;
	logic [5:0]  start_bit;
	logic [7:0]  bit_length;
	logic [15:0] interval;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  status;
	logic [3:0]  slot;
	logic [4:0]  slot_dlc;
	logic [15:0] slot_interval;

	bit                in_idle;
	bit                out_idle;
	logic [16:0]       id_pool[$];
	frame_slot_tracker tracker = new();

	can_frame_slot_assigner dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.output_index (output_index),
		.enabled      (enabled),
		.extended     (extended),
		.frame_id     (frame_id),
		.start_bit    (start_bit),
		.bit_length   (bit_length),
		.interval     (interval),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.slot         (slot),
		.slot_dlc     (slot_dlc),
		.slot_interval(slot_interval)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic assign_req_t make_assign(logic ext, logic [15:0] id, logic [5:0] sb,
			logic [7:0] len, logic [15:0] iv, logic en = 1'b1);
		assign_req_t r;
		r.cmd        = CMD_ASSIGN;
		r.out_idx    = 5'($urandom_range(0, 31));
		r.enabled    = en;
		r.extended   = ext;
		r.frame_id   = id;
		r.start_bit  = sb;
		r.bit_length = len;
		r.interval   = iv;
		return r;
	endfunction

	function automatic assign_req_t make_clear();
		assign_req_t r;
		r     = make_assign(1'($urandom), 16'($urandom), 6'($urandom), 8'($urandom),
			16'($urandom), 1'($urandom));
		r.cmd = CMD_CLEAR;
		return r;
	endfunction

	function automatic void build_id_pool(int count);
		logic [16:0] entry;
		id_pool.delete();
		for (int k = 0; k < count; k++) begin
			// neighbors one bit apart check the full-width identifier compare
			if (k > 0 && $urandom_range(0, 3) == 0) begin
				entry = id_pool[k - 1];
				entry[$urandom_range(0, 16)] ^= 1'b1;
			end else begin
				entry = 17'($urandom);
			end
			id_pool.push_back(entry);
		end
	endfunction

	function automatic assign_req_t random_request();
		assign_req_t r;
		logic [16:0] pick;
		int          roll;
		roll = $urandom_range(0, 99);
		if (roll < 3)
			return make_clear();
		pick = id_pool[$urandom_range(0, id_pool.size() - 1)];
		r    = make_assign(pick[16], pick[15:0], 6'($urandom), 8'($urandom_range(1, 64)),
			16'($urandom));
		if (roll < 15) begin
			// noise: disabled, empty or oversized signal
			case ($urandom_range(0, 2))
				0: begin
					r.enabled    = 1'b0;
					r.bit_length = 8'($urandom);
				end
				1: r.bit_length = '0;
				default: r.bit_length = 8'($urandom_range(MAX_BITS + 1, 255));
			endcase
			return r;
		end
		case ($urandom_range(0, 7))
			0: r.interval = '0;
			1: r.interval = 16'hFFFF;
			2: r.interval = 16'($urandom_range(1, 200));
			default: ;
		endcase
		case ($urandom_range(0, 7))
			0: r.bit_length = 8'd1;
			1: r.bit_length = 8'(MAX_BITS);
			default: ;
		endcase
		return r;
	endfunction

	task automatic send_request(assign_req_t r);
		int gap;
		gap = in_idle ? $urandom_range(0, 6) : 0;
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd          = r.cmd;
		output_index = r.out_idx;
		enabled      = r.enabled;
		extended     = r.extended;
		frame_id     = r.frame_id;
		start_bit    = r.start_bit;
		bit_length   = r.bit_length;
		interval     = r.interval;
		in_valid     = 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		tracker.accept_request(r);
		@(negedge clk);
	endtask

	// result side: random stall before each transaction, then take it
	initial begin
		int          hold;
		slot_reply_t got;
		out_stall = 1'b0;
		forever begin
			hold = out_idle ? $urandom_range(0, 6) : 0;
			if (hold > 0) begin
				out_stall = 1'b1;
				repeat (hold) @(negedge clk);
			end
			out_stall = 1'b0;
			do
				@(posedge clk);
			while (!out_valid);
			got.status = status;
			got.slot   = slot;
			got.dlc    = slot_dlc;
			got.period = slot_interval;
			tracker.compare_reply(got);
			@(negedge clk);
		end
	end

	initial begin
		int sent;
		int run_len;
		in_valid     = 1'b0;
		cmd          = CMD_CLEAR;
		output_index = '0;
		enabled      = 1'b0;
		extended     = 1'b0;
		frame_id     = '0;
		start_bit    = '0;
		bit_length   = '0;
		interval     = '0;
		in_idle      = 1'b1;
		out_idle     = 1'b1;
		arst_n       = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		send_request(make_clear());
		send_request(make_assign(1'b0, 16'h0001, 6'd0, 8'd8, 16'd10, 1'b0));
		send_request(make_assign(1'b0, 16'h0001, 6'd0, 8'd0, 16'd10));
		send_request(make_assign(1'b1, 16'h0001, 6'd0, 8'(MAX_BITS + 1), 16'd10));
		send_request(make_assign(1'b1, 16'hFFFF, 6'h3F, 8'hFF, 16'hFFFF));
		// default interval, shortest frame
		send_request(make_assign(1'b0, 16'h0000, 6'd0, 8'd1, 16'd0));
		// merge to the longest length code; interval stays the smaller one
		send_request(make_assign(1'b0, 16'h0000, 6'h3F, 8'(MAX_BITS), 16'hFFFF));
		send_request(make_assign(1'b0, 16'h0000, 6'd4, 8'd4, 16'd1));
		// same identifier, other frame format: new slot
		send_request(make_assign(1'b1, 16'h0000, 6'd0, 8'd16, 16'd50));
		send_request(make_assign(1'b1, 16'hFFFF, 6'd0, 8'(MAX_BITS), 16'hFFFF));
		// fill the remaining slots, then overflow
		for (int k = 0; k < NUM_SLOTS_DEF - 3; k++)
			send_request(make_assign(k[0], 16'h0100 + 16'(k), 6'($urandom),
				8'($urandom_range(1, 64)), 16'($urandom)));
		send_request(make_assign(1'b0, 16'h8000, 6'd0, 8'd8, 16'd20));
		send_request(make_assign(1'b1, 16'hFFFF, 6'd0, 8'd8, 16'd3));
		send_request(make_clear());

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			in_idle  = ($urandom_range(0, 3) != 0);
			out_idle = ($urandom_range(0, 3) != 0);
			build_id_pool($urandom_range(1, NUM_SLOTS_DEF + 4));
			send_request(make_clear());
			run_len = $urandom_range(4, 30);
			for (int k = 0; k < run_len; k++)
				send_request(random_request());
			sent += run_len + 1;
		end
		in_valid = 1'b0;

		while (tracker.pending_replies.size() != 0)
			@(posedge clk);
		// catch any stray result after the last one
		repeat (40) @(posedge clk);
		if (tracker.failures == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#1_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
